[design/mexp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, defaults, controller states and the command/status structs
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package mexp_pkg;

    // Fixed field widths of the channels.
    localparam int BASE_W  = 64;
    localparam int EXP_W   = 64;
    localparam int POWER_W = 32;
    localparam int CFG_W   = 32;

    // Default sizing of the exponent scan and the modulus.
    localparam int EXP_BITS_DEF = 64;
    localparam int MOD_BITS_DEF = 32;

    // Modulus after reset.
    localparam logic [CFG_W-1:0] MODULUS_RESET = 32'd1000000007;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ROUND,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // take a new input beat
        logic reduce_step;  // one bit of base reduction
        logic reduce_last;  // final bit of base reduction
        logic mul_step;     // one bit of both modular multiplications
        logic mul_first;    // first bit of a round: partial products start at zero
        logic mul_last;     // last bit of a round: commit square and accumulator
        logic out_load;     // move the accumulator into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;      // exponent bits still to scan are all zero
        logic exp_rest_zero; // all zero above the bit being scanned
    } t_sts;

endpackage

[design/mexp_ifs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Valid/ready channels for input items, results and the modulus write.
// ---------------------------------------------------------------------------

// Input channel: base and exponent.
interface mexp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::BASE_W-1:0]  base;
    logic [mexp_pkg::EXP_W-1:0]   exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

// Result channel: power.
interface mexp_out_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::POWER_W-1:0]  power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// Modulus write channel.
interface mexp_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/mexp_mstep.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular multiply step
// One bit of an MSB-first interleaved modular multiplication:
// result = (2 * acc + (add ? addend : 0)) mod m, for acc, addend below m.
// ---------------------------------------------------------------------------
module mexp_mstep #(
    parameter int MODULUS_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic [MODULUS_BITS:0]   i_mod,
    input  logic [MODULUS_BITS-1:0] i_acc,
    input  logic [MODULUS_BITS-1:0] i_addend,
    input  logic                    i_add,
    output logic [MODULUS_BITS-1:0] o_acc
);

    logic [MODULUS_BITS:0] dbl;
    logic [MODULUS_BITS:0] dbl_red;
    logic [MODULUS_BITS:0] sum;
    logic [MODULUS_BITS:0] sum_red;

    // Doubling stays below 2m, so one conditional subtract reduces it.
    assign dbl     = {i_acc, 1'b0};
    assign dbl_red = (dbl >= i_mod) ? (dbl - i_mod) : dbl;

    // Adding the multiplicand stays below 2m as well.
    assign sum     = dbl_red + (i_add ? {1'b0, i_addend} : '0);
    assign sum_red = (sum >= i_mod) ? (sum - i_mod) : sum;

    assign o_acc = sum_red[MODULUS_BITS-1:0];

endmodule

[design/mexp_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus, base and exponent shift registers, the running square,
// the accumulator and two bit-serial modular multiplier lanes.
// ---------------------------------------------------------------------------
module mexp_dp #(
    parameter int EXPONENT_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MODULUS_BITS  = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mexp_pkg::t_cmd                i_cmd,
    output mexp_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [mexp_pkg::BASE_W-1:0]   i_base,
    input  logic [mexp_pkg::EXP_W-1:0]    i_exponent,
    output logic [mexp_pkg::POWER_W-1:0]  o_power
);

    localparam int PowW = mexp_pkg::POWER_W;
    localparam int BaseW = mexp_pkg::BASE_W;

    logic [MODULUS_BITS-1:0]  r_mod;
    logic [BaseW-1:0]         r_base;
    logic [EXPONENT_BITS-1:0] r_exp;
    logic [MODULUS_BITS-1:0]  r_sq;
    logic [MODULUS_BITS-1:0]  r_acc;
    logic [MODULUS_BITS-1:0]  r_sq_sh;
    logic [MODULUS_BITS-1:0]  r_acc_sh;
    logic [MODULUS_BITS-1:0]  r_pa;
    logic [MODULUS_BITS-1:0]  r_ps;
    logic [PowW-1:0]          r_power;

    logic [MODULUS_BITS:0]    mod_eff;
    logic [MODULUS_BITS-1:0]  sq_lane_in;
    logic [MODULUS_BITS-1:0]  sq_lane_addend;
    logic                     sq_lane_add;
    logic [MODULUS_BITS-1:0]  sq_lane_out;
    logic [MODULUS_BITS-1:0]  acc_lane_in;
    logic [MODULUS_BITS-1:0]  acc_lane_out;
    logic [MODULUS_BITS-1:0]  n_acc;

    // A zero modulus stands for 2^MODULUS_BITS.
    assign mod_eff = (r_mod == '0) ? {1'b1, {MODULUS_BITS{1'b0}}} : {1'b0, r_mod};

    // Square lane: also reduces the base, one base bit per cycle, MSB first.
    always_comb begin
        if (i_cmd.reduce_step) begin
            sq_lane_in     = r_ps;
            sq_lane_addend = {{(MODULUS_BITS-1){1'b0}}, r_base[BaseW-1]};
            sq_lane_add    = 1'b1;
        end else begin
            sq_lane_in     = i_cmd.mul_first ? '0 : r_ps;
            sq_lane_addend = r_sq;
            sq_lane_add    = r_sq_sh[MODULUS_BITS-1];
        end
    end

    mexp_mstep #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_sq_lane (
        .i_mod    (mod_eff),
        .i_acc    (sq_lane_in),
        .i_addend (sq_lane_addend),
        .i_add    (sq_lane_add),
        .o_acc    (sq_lane_out)
    );

    // Accumulator lane: accumulator times square.
    assign acc_lane_in = i_cmd.mul_first ? '0 : r_pa;

    mexp_mstep #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_acc_lane (
        .i_mod    (mod_eff),
        .i_acc    (acc_lane_in),
        .i_addend (r_sq),
        .i_add    (r_acc_sh[MODULUS_BITS-1]),
        .o_acc    (acc_lane_out)
    );

    // The accumulator takes the product only where the exponent bit is set.
    assign n_acc = r_exp[0] ? acc_lane_out : r_acc;

    // Modulus register, written through the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mexp_pkg::MODULUS_RESET[MODULUS_BITS-1:0];
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data[MODULUS_BITS-1:0];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_exp  <= i_exponent[EXPONENT_BITS-1:0];
            r_acc  <= {{(MODULUS_BITS-1){1'b0}}, 1'b1};
            r_ps   <= '0;
        end else if (i_cmd.reduce_step) begin
            r_base <= {r_base[BaseW-2:0], 1'b0};
            r_ps   <= sq_lane_out;
            if (i_cmd.reduce_last) begin
                r_sq     <= sq_lane_out;
                r_sq_sh  <= sq_lane_out;
                r_acc_sh <= r_acc;
            end
        end else if (i_cmd.mul_step) begin
            if (i_cmd.mul_last) begin
                r_acc    <= n_acc;
                r_acc_sh <= n_acc;
                r_sq     <= sq_lane_out;
                r_sq_sh  <= sq_lane_out;
                r_exp    <= r_exp >> 1;
            end else begin
                r_pa     <= acc_lane_out;
                r_ps     <= sq_lane_out;
                r_acc_sh <= r_acc_sh << 1;
                r_sq_sh  <= r_sq_sh << 1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_power <= PowW'(r_acc);
        end
    end

    assign o_power            = r_power;
    assign o_sts.exp_zero     = (r_exp == '0);
    assign o_sts.exp_rest_zero = ((r_exp >> 1) == '0);

endmodule

[design/mexp_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, one multiplication round per exponent bit up
// to the highest set one and the hand-off to the output register; owns
// both channel handshakes.
module mexp_ctrl #(
    parameter int EXPONENT_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MODULUS_BITS  = mexp_pkg::MOD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mexp_pkg::t_sts  i_sts,
    output mexp_pkg::t_cmd  o_cmd
);

    localparam int BaseW = mexp_pkg::BASE_W;
    localparam int CntW  = $clog2((BaseW > MODULUS_BITS) ? BaseW : MODULUS_BITS);
    localparam int RndW  = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

    mexp_pkg::t_state r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [RndW-1:0]  r_rnd, n_rnd;
    logic             r_out_valid, n_out_valid;

    logic in_fire;
    logic out_free;
    logic cnt_done;

    assign in_fire  = i_in_valid && (r_state == mexp_pkg::ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_done = (r_cnt == '0);

    // Next state and counters.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rnd   = r_rnd;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = mexp_pkg::ST_REDUCE;
                    n_cnt   = CntW'(BaseW - 1);
                end
            end
            mexp_pkg::ST_REDUCE: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) begin
                    if (i_sts.exp_zero) begin
                        n_state = mexp_pkg::ST_FINISH;
                    end else begin
                        n_state = mexp_pkg::ST_ROUND;
                        n_cnt   = CntW'(MODULUS_BITS - 1);
                        n_rnd   = RndW'(EXPONENT_BITS - 1);
                    end
                end
            end
            mexp_pkg::ST_ROUND: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) begin
                    if ((r_rnd == '0) || i_sts.exp_rest_zero) begin
                        n_state = mexp_pkg::ST_FINISH;
                    end else begin
                        n_cnt = CntW'(MODULUS_BITS - 1);
                        n_rnd = r_rnd - 1'b1;
                    end
                end
            end
            mexp_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands and output valid.
    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                o_cmd.load = in_fire;
            end
            mexp_pkg::ST_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                o_cmd.reduce_last = cnt_done;
            end
            mexp_pkg::ST_ROUND: begin
                o_cmd.mul_step  = 1'b1;
                o_cmd.mul_first = (r_cnt == CntW'(MODULUS_BITS - 1));
                o_cmd.mul_last  = cnt_done;
            end
            mexp_pkg::ST_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rnd       <= n_rnd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == mexp_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/modular_exponentiation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// with a controller and a datapath of two bit-serial modular multipliers.
// ---------------------------------------------------------------------------
//  Port    Direction  Beat contents
//  i_in    sink       base (64 bits), exponent (64 bits)
//  o_out   source     power (32 bits)
//  i_cfg   sink       modulus write data (32 bits), always ready
//
//  An item first reduces the base one bit at a time, MSB first; then each
//  exponent bit up to the highest set bit among the low EXPONENT_BITS bits
//  takes one MSB-first pass of the two multiplier lanes, which run together
//  (no pass for a zero exponent).
//  Reset restores the modulus to 1000000007 and leaves the block idle.
//  One item is in work at a time; a result waiting in the output register
//  does not block the next item until that item's own result is ready.
// ---------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXPONENT_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MODULUS_BITS  = mexp_pkg::MOD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_in_if.sink     i_in,
    mexp_out_if.source  o_out,
    mexp_cfg_if.sink    i_cfg
);

    mexp_pkg::t_cmd cmd;
    mexp_pkg::t_sts sts;
    logic           cfg_we;

    // The modulus register takes a write in any cycle.
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // Sequencer.
    mexp_ctrl #(
        .EXPONENT_BITS (EXPONENT_BITS),
        .MODULUS_BITS  (MODULUS_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    mexp_dp #(
        .EXPONENT_BITS (EXPONENT_BITS),
        .MODULUS_BITS  (MODULUS_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg.data),
        .i_base     (i_in.base),
        .i_exponent (i_in.exponent),
        .o_power    (o_out.power)
    );

endmodule

[tb/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base/exponent beats through a queue-fed driver and checks every power
// beat against a square-and-multiply predictor. The modulus is rewritten
// between phases while the block is idle, and both sides stall at random.
// ---------------------------------------------------------------------------
module tb_modular_exponentiation;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 7;
    localparam int MAX_WAIT         = 18;
    localparam int RANDOM_PER_PHASE = 25;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 100;
    // The limit outlasts one item at full exponent width.
    localparam int WATCHDOG_LIMIT   = 10000;

    typedef struct packed {
        logic [mexp_pkg::BASE_W-1:0] base;
        logic [mexp_pkg::EXP_W-1:0]  exponent;
    } t_operands;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mexp_in_if  in_if ();
    mexp_out_if out_if ();
    mexp_cfg_if cfg_if ();

    // Testbench-side drivers of the channel inputs, known from time zero.
    logic                         in_valid    = 1'b0;
    logic [mexp_pkg::BASE_W-1:0]  in_base     = '0;
    logic [mexp_pkg::EXP_W-1:0]   in_exponent = '0;
    logic                         out_ready   = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic [mexp_pkg::CFG_W-1:0]   cfg_data    = '0;

    assign in_if.valid    = in_valid;
    assign in_if.base     = in_base;
    assign in_if.exponent = in_exponent;
    assign out_if.ready   = out_ready;
    assign cfg_if.valid   = cfg_valid;
    assign cfg_if.data    = cfg_data;

    modular_exponentiation uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_operands                     pending_operands[$];
    logic [mexp_pkg::POWER_W-1:0]  expected_powers[$];
    logic [mexp_pkg::CFG_W-1:0]    modulus_shadow = mexp_pkg::MODULUS_RESET;
    int                            errors         = 0;
    int                            quiet_cycles   = 0;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   in_gap    = 0;
    int   out_stall = 0;
    int   in_calm   = 0;
    int   out_calm  = 0;

    // Right-to-left square-and-multiply; a zero modulus stands for 2^32.
    function automatic logic [mexp_pkg::POWER_W-1:0] mod_power(
        logic [mexp_pkg::BASE_W-1:0] b,
        logic [mexp_pkg::EXP_W-1:0]  e,
        logic [mexp_pkg::CFG_W-1:0]  mod);
        logic [63:0] m;
        logic [63:0] square;
        logic [63:0] acc;
        m      = (mod == '0) ? 64'h1_0000_0000 : {32'd0, mod};
        square = b % m;
        acc    = 64'd1;
        for (int i = 0; i < mexp_pkg::EXP_W; i++) begin
            if (e[i]) begin
                acc = (acc * square) % m;
            end
            square = (square * square) % m;
        end
        return acc[mexp_pkg::POWER_W-1:0];
    endfunction

    // Wait length for one beat, with occasional runs of back-to-back beats.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(3, 12);
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Input driver: presents the next pending operands after a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (pending_operands.size() > 0) begin
                t_operands next_ops;
                next_ops    = pending_operands.pop_front();
                in_valid    <= 1'b1;
                in_base     <= next_ops.base;
                in_exponent <= next_ops.exponent;
                in_gap      <= draw_wait(in_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result sink: drops ready for a random number of cycles after each beat.
    always @(negedge i_clk) begin
        if (out_taken) begin
            int w;
            w = draw_wait(out_calm);
            if (w > 0) begin
                out_ready <= 1'b0;
                out_stall <= w - 1;
            end
        end else if (!out_ready) begin
            if (out_stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_stall <= out_stall - 1;
            end
        end
    end

    // Monitor: predicts on accepted inputs, checks accepted results, and
    // watches for a stalled run.
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && in_valid && in_if.ready;
        out_taken <= i_rst_n && out_if.valid && out_ready;
        if (i_rst_n) begin
            if (in_valid && in_if.ready) begin
                expected_powers.push_back(mod_power(in_base, in_exponent, modulus_shadow));
            end
            if (out_if.valid && out_ready) begin
                if (expected_powers.size() == 0) begin
                    $error("unexpected power beat: actual %0d", out_if.power);
                    errors++;
                end else begin
                    logic [mexp_pkg::POWER_W-1:0] want;
                    want = expected_powers.pop_front();
                    if (out_if.power !== want) begin
                        $error("power mismatch: expected %0d, actual %0d",
                               want, out_if.power);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_if.ready) begin
                modulus_shadow <= cfg_data;
            end
            if ((in_valid && in_if.ready) || (out_if.valid && out_ready) ||
                (cfg_valid && cfg_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(logic [mexp_pkg::BASE_W-1:0] b,
                              logic [mexp_pkg::EXP_W-1:0] e);
        t_operands ops;
        ops.base     = b;
        ops.exponent = e;
        pending_operands.push_back(ops);
    endtask

    // Returns once every queued item has produced its result.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_operands.size() != 0 || in_valid || expected_powers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_modulus(logic [mexp_pkg::CFG_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short exponents to keep the run brief; a few use all 64 bits.
    task automatic add_random_items(int count, logic [mexp_pkg::CFG_W-1:0] mod);
        logic [63:0]                 m;
        logic [mexp_pkg::BASE_W-1:0] b;
        logic [mexp_pkg::EXP_W-1:0]  e;
        int                          w;
        m = (mod == '0) ? 64'h1_0000_0000 : {32'd0, mod};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0: b = {32'd0, $urandom_range(0, 20)};
                1: b = '1;
                2: b = m * {32'd0, $urandom_range(0, 1000000)} +
                       {32'd0, $urandom_range(0, 3)};
                3: b = {32'd0, $urandom};
                default: b = {$urandom, $urandom};
            endcase
            w = $urandom_range(0, 19);
            if (w == 0) begin
                e = '0;
            end else if (w <= 2) begin
                e = {$urandom, $urandom};
            end else begin
                w = (w <= 6) ? $urandom_range(17, 48) : $urandom_range(1, 16);
                e = {$urandom, $urandom} >> (mexp_pkg::EXP_W - w);
                e = e | (64'd1 << (w - 1));
            end
            queue_item(b, e);
        end
    endtask

    // Stimulus: directed corners at each modulus of interest, then random.
    initial begin
        logic [mexp_pkg::CFG_W-1:0] rand_mod;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset modulus: field extremes and a base equal to the modulus.
        queue_item('0, '0);
        queue_item('0, 64'd1);
        queue_item('1, '1);
        queue_item('1, '0);
        queue_item('0, '1);
        queue_item(64'd1, '1);
        queue_item(64'd2, 64'd10);
        queue_item(64'd1000000007, 64'd5);
        queue_item(64'd1000000006, 64'd2);
        add_random_items(RANDOM_PER_PHASE, mexp_pkg::MODULUS_RESET);

        // Modulus of one: zero exponent still yields one.
        load_modulus(32'd1);
        queue_item(64'd5, '0);
        queue_item(64'd5, 64'd3);
        queue_item('1, '1);
        add_random_items(RANDOM_PER_PHASE, 32'd1);

        // Modulus of zero means 2^32, so results can reach all ones.
        load_modulus(32'd0);
        queue_item('1, 64'd1);
        queue_item('1, '1);
        queue_item(64'd2, 64'd31);
        queue_item(64'd2, 64'd32);
        add_random_items(RANDOM_PER_PHASE, 32'd0);

        // Largest modulus.
        load_modulus(32'hFFFF_FFFF);
        queue_item(64'hFFFF_FFFE, 64'd2);
        queue_item(64'hFFFF_FFFF, 64'd7);
        add_random_items(RANDOM_PER_PHASE, 32'hFFFF_FFFF);

        load_modulus(32'd2);
        add_random_items(RANDOM_PER_PHASE, 32'd2);
        load_modulus(32'd3);
        add_random_items(RANDOM_PER_PHASE, 32'd3);
        load_modulus(32'd65536);
        add_random_items(RANDOM_PER_PHASE, 32'd65536);
        load_modulus(32'hFFFF_FFFB);
        add_random_items(RANDOM_PER_PHASE, 32'hFFFF_FFFB);

        rand_mod = $urandom;
        load_modulus(rand_mod);
        add_random_items(RANDOM_PER_PHASE, rand_mod);
        rand_mod = $urandom_range(4, 1000);
        load_modulus(rand_mod);
        add_random_items(RANDOM_PER_PHASE, rand_mod);

        load_modulus(mexp_pkg::MODULUS_RESET);
        add_random_items(RANDOM_PER_PHASE, mexp_pkg::MODULUS_RESET);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_powers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/mexp_pkg.sv
design/mexp_ifs.sv
design/mexp_mstep.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
